@@ sv/rla_pkg.sv @@
// ----------------------------------------------------------------------------
// Regression loss accumulator package
// Shared command codes, register indexes, loss mode codes, limits and types.
// ----------------------------------------------------------------------------
package rla_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] LOSS_SQUARED  = 2'd0;
    localparam logic [1:0] LOSS_ABS      = 2'd1;
    localparam logic [1:0] LOSS_MISCLASS = 2'd2;

    localparam logic REG_LOSS_MODE     = 1'b0;
    localparam logic REG_FEATURE_COUNT = 1'b1;

    localparam logic [1:0] LOSS_MODE_RESET     = 2'd0;
    localparam logic [8:0] FEATURE_COUNT_RESET = 9'd16;

    localparam logic [62:0] LOSS_MAX = '1;
    localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

    typedef struct packed {
        logic [1:0] loss_mode;
        logic [8:0] feature_count;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_RES,
        ST_MAG,
        ST_SQ_HH,
        ST_SQ_HL,
        ST_SQ_LL,
        ST_SQ_SUM,
        ST_EMIT
    } t_state;

endpackage

@@ sv/rla_in_if.sv @@
// ----------------------------------------------------------------------------
// Regression loss accumulator input channel
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface rla_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [7:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] feature_value;
    logic signed [31:0] response;

    modport source (
        output valid, command, coef_index, coef_value, feature_value, response,
        input  ready
    );
    modport sink (
        input  valid, command, coef_index, coef_value, feature_value, response,
        output ready
    );
endinterface

@@ sv/rla_out_if.sv @@
// ----------------------------------------------------------------------------
// Regression loss accumulator result channel
// Valid/ready channel carrying one row result per transfer.
// ----------------------------------------------------------------------------
interface rla_out_if;
    logic        valid;
    logic        ready;
    logic [62:0] row_loss;
    logic [62:0] total_loss;
    logic        predicted_label;

    modport source (
        output valid, row_loss, total_loss, predicted_label,
        input  ready
    );
    modport sink (
        input  valid, row_loss, total_loss, predicted_label,
        output ready
    );
endinterface

@@ sv/rla_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered and appears the cycle after the read.
// ----------------------------------------------------------------------------
module rla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rla_cfg.sv @@
// ----------------------------------------------------------------------------
// Regression loss accumulator configuration registers
// APB-style register file holding the loss mode and the feature count.
// ----------------------------------------------------------------------------
module rla_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rla_pkg::t_cfg o_cfg
);

    rla_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loss_mode     <= rla_pkg::LOSS_MODE_RESET;
            r_cfg.feature_count <= rla_pkg::FEATURE_COUNT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                rla_pkg::REG_LOSS_MODE:     r_cfg.loss_mode     <= pwdata[1:0];
                rla_pkg::REG_FEATURE_COUNT: r_cfg.feature_count <= pwdata[8:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rla_pkg::REG_LOSS_MODE:     prdata = {30'd0, r_cfg.loss_mode};
            rla_pkg::REG_FEATURE_COUNT: prdata = {23'd0, r_cfg.feature_count};
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/regression_loss_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// Regression loss accumulator
// Multiply-accumulates streamed features against stored coefficients and
// emits the row loss and a saturating running total at the end of each row.
// ----------------------------------------------------------------------------
//  Channel    Direction  Transfer moves
//  i_item     in         command, coef_index, coef_value, feature_value, response
//  o_result   out        row_loss, total_loss, predicted_label
//  APB        in/out     loss_mode at 0x0, feature_count at 0x4
//
// Loads, clears and reserved commands are completed in the idle state.
// A feature that does not end a row goes through coefficient read,
// multiply and accumulate, all around the single coefficient memory port.
// A row's last feature passes through the residual and magnitude states to
// the emit state; for squared loss with an in-range residual it first reuses
// the multiplier in three partial products.
// Reset is synchronous and needs no clearing pass; a finished result waits in
// the output register while the next items are taken, and only a further row
// end stalls on a full output register.
// ----------------------------------------------------------------------------
module regression_loss_accumulator_top #(
    parameter int MAX_FEATURES = 256,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rla_in_if.sink      i_item,
    rla_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW = ($clog2(MAX_FEATURES + 1) > 9) ? $clog2(MAX_FEATURES + 1) : 9;

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [63:0] d;
        d = a - b;
        if ((a[63] != b[63]) && (d[63] != a[63])) begin
            d = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return d;
    endfunction

    rla_pkg::t_cfg cfg;

    rla_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rla_pkg::t_state r_state;
    rla_pkg::t_state n_state;

    logic [AW-1:0]           r_pos;
    logic signed [63:0]      r_acc;
    logic signed [63:0]      r_pred;
    logic signed [63:0]      r_res;
    logic signed [63:0]      r_prod;
    logic signed [31:0]      r_feat;
    logic signed [31:0]      r_resp;
    logic                    r_final;
    logic                    r_label;
    logic [39:0]             r_mag;
    logic [63:0]             r_loss;
    logic [62:0]             r_total;
    logic                    r_out_valid;
    logic [62:0]             r_row_loss;
    logic [62:0]             r_total_loss;
    logic                    r_pred_label;

    logic                    accept;
    logic                    item_ready;
    logic                    mem_en;
    logic                    mem_we;
    logic [AW-1:0]           mem_addr;
    logic [VALUE_WIDTH-1:0]  mem_rdata;
    logic [31:0]             idx_ext;
    logic                    idx_ok;
    logic signed [VALUE_WIDTH-1:0] feat_lo;
    logic signed [VALUE_WIDTH-1:0] resp_lo;
    logic signed [VALUE_WIDTH-1:0] coef_lo;
    logic [CW-1:0]           fc_ext;
    logic [CW-1:0]           eff_cnt;
    logic                    is_final;
    logic signed [31:0]      mul_a;
    logic signed [31:0]      mul_b;
    logic signed [63:0]      acc_new;
    logic [63:0]             res_mag;
    logic signed [32:0]      mis_diff;
    logic [32:0]             mis_mag;
    logic [63:0]             sq_sum;
    logic [63:0]             tot_sum;
    logic                    can_emit;

    assign accept   = i_item.valid && item_ready;
    assign idx_ext  = 32'(i_item.coef_index);
    assign idx_ok   = idx_ext < 32'(MAX_FEATURES);
    assign feat_lo  = i_item.feature_value[VALUE_WIDTH-1:0];
    assign resp_lo  = i_item.response[VALUE_WIDTH-1:0];
    assign coef_lo  = mem_rdata;
    assign fc_ext   = CW'(cfg.feature_count);
    assign eff_cnt  = (cfg.feature_count == 9'd0) ? CW'(1) :
                      (fc_ext > CW'(MAX_FEATURES)) ? CW'(MAX_FEATURES) : fc_ext;
    assign is_final = (CW'(r_pos) + CW'(1)) >= eff_cnt;
    assign acc_new  = sat_add(r_acc, r_prod >>> 16);
    assign res_mag  = r_res[63] ? (~r_res + 64'sd1) : r_res;
    assign mis_diff = 33'(r_resp) - (r_label ? rla_pkg::ONE_Q16 : 33'sd0);
    assign mis_mag  = mis_diff[32] ? 33'(-mis_diff) : mis_diff;
    assign sq_sum   = r_loss + (r_prod >> 16);
    assign tot_sum  = {1'b0, r_total} + {1'b0, r_loss[62:0]};
    assign can_emit = !r_out_valid || o_result.ready;

    rla_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_FEATURES)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_item.coef_value[VALUE_WIDTH-1:0]),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rla_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        item_ready = 1'b0;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_pos;
        mul_a      = r_feat;
        mul_b      = 32'(coef_lo);
        unique case (r_state)
            rla_pkg::ST_IDLE: begin
                item_ready = 1'b1;
                if (accept) begin
                    if (i_item.command == rla_pkg::CMD_LOAD) begin
                        mem_en   = idx_ok;
                        mem_we   = 1'b1;
                        mem_addr = idx_ext[AW-1:0];
                    end else if (i_item.command == rla_pkg::CMD_DATA) begin
                        mem_en  = 1'b1;
                        n_state = rla_pkg::ST_MUL;
                    end
                end
            end
            rla_pkg::ST_MUL: begin
                n_state = rla_pkg::ST_ACC;
            end
            rla_pkg::ST_ACC: begin
                n_state = r_final ? rla_pkg::ST_RES : rla_pkg::ST_IDLE;
            end
            rla_pkg::ST_RES: begin
                n_state = rla_pkg::ST_MAG;
            end
            rla_pkg::ST_MAG: begin
                if ((cfg.loss_mode == rla_pkg::LOSS_ABS) ||
                    (cfg.loss_mode == rla_pkg::LOSS_MISCLASS) ||
                    (|res_mag[63:40])) begin
                    n_state = rla_pkg::ST_EMIT;
                end else begin
                    n_state = rla_pkg::ST_SQ_HH;
                end
            end
            rla_pkg::ST_SQ_HH: begin
                mul_a   = 32'(r_mag[39:20]);
                mul_b   = 32'(r_mag[39:20]);
                n_state = rla_pkg::ST_SQ_HL;
            end
            rla_pkg::ST_SQ_HL: begin
                mul_a   = 32'(r_mag[39:20]);
                mul_b   = 32'(r_mag[19:0]);
                n_state = rla_pkg::ST_SQ_LL;
            end
            rla_pkg::ST_SQ_LL: begin
                mul_a   = 32'(r_mag[19:0]);
                mul_b   = 32'(r_mag[19:0]);
                n_state = rla_pkg::ST_SQ_SUM;
            end
            rla_pkg::ST_SQ_SUM: begin
                n_state = rla_pkg::ST_EMIT;
            end
            rla_pkg::ST_EMIT: begin
                if (can_emit) begin
                    n_state = rla_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_acc       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == rla_pkg::ST_EMIT) && can_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                rla_pkg::ST_IDLE: begin
                    if (accept && (i_item.command == rla_pkg::CMD_CLEAR)) begin
                        r_total <= '0;
                    end
                end
                rla_pkg::ST_ACC: begin
                    if (r_final) begin
                        r_acc <= '0;
                        r_pos <= '0;
                    end else begin
                        r_acc <= acc_new;
                        r_pos <= r_pos + AW'(1);
                    end
                end
                rla_pkg::ST_EMIT: begin
                    if (can_emit) begin
                        r_total <= tot_sum[63] ? rla_pkg::LOSS_MAX : tot_sum[62:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            rla_pkg::ST_IDLE: begin
                r_feat  <= 32'(feat_lo);
                r_resp  <= 32'(resp_lo);
                r_final <= is_final;
            end
            rla_pkg::ST_ACC: begin
                r_pred <= acc_new;
            end
            rla_pkg::ST_RES: begin
                r_label <= r_pred > 64'sd0;
                r_res   <= sat_sub(64'(r_resp), r_pred);
            end
            rla_pkg::ST_MAG: begin
                r_mag <= res_mag[39:0];
                if (cfg.loss_mode == rla_pkg::LOSS_ABS) begin
                    r_loss <= res_mag[63] ? {1'b0, rla_pkg::LOSS_MAX} : res_mag;
                end else if (cfg.loss_mode == rla_pkg::LOSS_MISCLASS) begin
                    r_loss <= 64'(mis_mag);
                end else begin
                    r_loss <= {1'b0, rla_pkg::LOSS_MAX};
                end
            end
            rla_pkg::ST_SQ_HL: begin
                r_loss <= 64'(r_prod) << 24;
            end
            rla_pkg::ST_SQ_LL: begin
                r_loss <= r_loss + (64'(r_prod) << 5);
            end
            rla_pkg::ST_SQ_SUM: begin
                r_loss <= sq_sum[63] ? {1'b0, rla_pkg::LOSS_MAX} : sq_sum;
            end
            rla_pkg::ST_EMIT: begin
                if (can_emit) begin
                    r_row_loss   <= r_loss[62:0];
                    r_total_loss <= tot_sum[63] ? rla_pkg::LOSS_MAX : tot_sum[62:0];
                    r_pred_label <= r_label;
                end
            end
            default: begin
            end
        endcase
    end

    assign i_item.ready             = item_ready;
    assign o_result.valid           = r_out_valid;
    assign o_result.row_loss        = r_row_loss;
    assign o_result.total_loss      = r_total_loss;
    assign o_result.predicted_label = r_pred_label;

endmodule
